### sv/a32lfc_pkg.sv
package a32lfc_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned FLEN_W  = 31;
  localparam int unsigned COUNT_W = 31;

  localparam logic [15:0] ADLER_MOD    = 16'd65521;
  localparam logic [31:0] HDR_BYTES    = 32'd4;
  localparam logic [31:0] MIN_NAME_LEN = 32'd2;

  localparam logic [FLEN_W-1:0] MIN_LEN_RESET = 31'd10;
  localparam logic [FLEN_W-1:0] MAX_LEN_RESET = 31'd67108864;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    SEC_NAME    = 2'd0,
    SEC_PAYLOAD = 2'd1,
    SEC_END     = 2'd2
  } section_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_LENGTH   = 2'd1,
    ST_CHECKSUM     = 2'd2,
    ST_BAD_NAME_LEN = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    REG_MIN_FRAME_LEN = 8'd0,
    REG_MAX_FRAME_LEN = 8'd1
  } reg_index_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    section_t          section;
    logic              last;
    status_t           status;
    logic [FLEN_W-1:0] frame_length;
  } result_t;

endpackage

### sv/adler32_length_frame_checker.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  s_tdata: stream_byte
// m_*       out  m_tvalid / m_tready  m_tdata: data_byte, status, frame_length;
//                                     m_tuser: section; m_tlast: last
// cfg_*     in   cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// One byte per cycle while s_tready is high: each accepted byte is decoded,
// and name-length and body bytes are folded into the Adler-32 sums in the
// cycle they are taken; a byte's result, if any, is registered into a
// two-entry output queue. The Adler-32 update is two mod-65521 adds per byte.
// s_tready drops only while both queue entries hold results.
// rst is synchronous and active high; it restores both registers to defaults.
module adler32_length_frame_checker
  import a32lfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] stream_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // [7:0] data_byte, [9:8] status,
                                  // [40:10] frame_length, [47:41] zero
  output logic [1:0]  m_tuser,    // [1:0] section
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  phase_t              phase, phase_next;
  logic [COUNT_W-1:0]  byte_count, byte_count_next;
  logic [31:0]         frame_len_reg, frame_len_reg_next;
  logic [31:0]         name_len_reg, name_len_reg_next;
  logic [15:0]         adler_low, adler_low_next;
  logic [15:0]         adler_high, adler_high_next;
  logic [31:0]         trailer_shift, trailer_shift_next;
  logic [FLEN_W-1:0]   min_frame_len, max_frame_len;

  result_t             res;
  logic                res_valid;
  result_t             q0, q1;
  logic                q0_valid, q1_valid;

  logic                accept, push, pop;
  logic [DATA_W-1:0]   b;
  logic [31:0]         len_shift, trailer_new;
  logic                len_bad;
  logic [31:0]         off_p4, off_p1, len_m8;
  logic [32:0]         name_end;
  logic [16:0]         low_sum, high_sum;
  logic [15:0]         low_upd, high_upd;
  logic                sum_bad, name_bad, frame_done;

  assign b         = s_tdata;
  assign s_tready  = !q1_valid;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Adler-32 update with conditional subtract
  assign low_sum  = {1'b0, adler_low} + {9'd0, b};
  assign low_upd  = (low_sum >= {1'b0, ADLER_MOD}) ? 16'(low_sum - {1'b0, ADLER_MOD})
                                                   : low_sum[15:0];
  assign high_sum = {1'b0, adler_high} + {1'b0, low_upd};
  assign high_upd = (high_sum >= {1'b0, ADLER_MOD}) ? 16'(high_sum - {1'b0, ADLER_MOD})
                                                    : high_sum[15:0];

  assign len_shift = {frame_len_reg[23:0], b};
  assign len_bad   = len_shift[31]
                  || (len_shift[30:0] < min_frame_len)
                  || (len_shift[30:0] > max_frame_len)
                  || (len_shift < 2 * HDR_BYTES);

  assign off_p4      = {1'b0, byte_count} + HDR_BYTES;
  assign off_p1      = {1'b0, byte_count} + 32'd1;
  assign name_end    = {1'b0, name_len_reg} + {1'b0, HDR_BYTES};
  assign len_m8      = frame_len_reg - 2 * HDR_BYTES;
  assign trailer_new = {trailer_shift[23:0], b};
  assign frame_done  = (off_p1 == frame_len_reg);
  assign sum_bad     = ({adler_high, adler_low} != trailer_new);
  assign name_bad    = name_len_reg[31] || (name_len_reg < MIN_NAME_LEN)
                    || (name_len_reg > len_m8);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (byte_count[1:0] == 2'(HDR_BYTES - 1)) begin
            phase_next = len_bad ? PH_HALT : PH_BODY;
          end
        end
        PH_BODY: begin
          if (off_p4 >= frame_len_reg && frame_done) begin
            phase_next = (sum_bad || name_bad) ? PH_HALT : PH_HEADER;
          end
        end
        PH_HALT: phase_next = PH_HALT;
        default: phase_next = PH_HALT;
      endcase
    end
  end

  always_comb begin
    byte_count_next    = byte_count;
    frame_len_reg_next = frame_len_reg;
    name_len_reg_next  = name_len_reg;
    adler_low_next     = adler_low;
    adler_high_next    = adler_high;
    trailer_shift_next = trailer_shift;
    res                = '0;
    res_valid          = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          frame_len_reg_next = len_shift;
          byte_count_next    = byte_count + 1'b1;
          if (byte_count[1:0] == 2'(HDR_BYTES - 1)) begin
            byte_count_next = '0;
            if (len_bad) begin
              res_valid        = 1'b1;
              res.section      = SEC_END;
              res.last         = 1'b1;
              res.status       = ST_BAD_LENGTH;
              res.frame_length = len_shift[FLEN_W-1:0];
            end else begin
              name_len_reg_next  = '0;
              trailer_shift_next = '0;
              adler_low_next     = 16'd1;
              adler_high_next    = 16'd0;
            end
          end
        end
        PH_BODY: begin
          byte_count_next = byte_count + 1'b1;
          if ({1'b0, byte_count} < HDR_BYTES) begin
            name_len_reg_next = {name_len_reg[23:0], b};
            adler_low_next    = low_upd;
            adler_high_next   = high_upd;
          end else if (off_p4 < frame_len_reg) begin
            adler_low_next  = low_upd;
            adler_high_next = high_upd;
            res_valid       = 1'b1;
            res.data_byte   = b;
            res.section     = ({2'b00, byte_count} < name_end) ? SEC_NAME : SEC_PAYLOAD;
          end else begin
            trailer_shift_next = trailer_new;
            if (frame_done) begin
              byte_count_next    = '0;
              frame_len_reg_next = '0;
              adler_low_next     = 16'd1;
              adler_high_next    = 16'd0;
              res_valid          = 1'b1;
              res.section        = SEC_END;
              res.last           = 1'b1;
              res.frame_length   = frame_len_reg[FLEN_W-1:0];
              if (sum_bad) begin
                res.status = ST_CHECKSUM;
              end else if (name_bad) begin
                res.status = ST_BAD_NAME_LEN;
              end else begin
                res.status = ST_OK;
              end
            end
          end
        end
        PH_HALT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_count    <= '0;
      frame_len_reg <= '0;
      name_len_reg  <= '0;
      adler_low     <= 16'd1;
      adler_high    <= 16'd0;
      trailer_shift <= '0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      frame_len_reg <= frame_len_reg_next;
      name_len_reg  <= name_len_reg_next;
      adler_low     <= adler_low_next;
      adler_high    <= adler_high_next;
      trailer_shift <= trailer_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_len <= MIN_LEN_RESET;
      max_frame_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_FRAME_LEN: min_frame_len <= cfg_data;
        REG_MAX_FRAME_LEN: max_frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Two-entry result queue; a push never meets a full queue since s_tready
  // is low while the second entry is occupied.
  assign push = accept && res_valid;
  assign pop  = q0_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q0_valid <= 1'b0;
      q1_valid <= 1'b0;
    end else begin
      if (pop) begin
        q0_valid <= q1_valid || push;
        q1_valid <= 1'b0;
      end else if (push) begin
        q0_valid <= 1'b1;
        q1_valid <= q0_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= q1_valid ? q1 : res;
    end else if (push && !q0_valid) begin
      q0 <= res;
    end
    if (push && q0_valid && !pop) begin
      q1 <= res;
    end
  end

  assign m_tvalid = q0_valid;
  assign m_tdata  = {7'd0, q0.frame_length, q0.status, q0.data_byte};
  assign m_tuser  = q0.section;
  assign m_tlast  = q0.last;

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |-> !res_valid)
    else $error("result produced while halted");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    q1_valid |-> q0_valid)
    else $error("second queue entry holds data without a head");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    push && res.last && res.status != ST_OK |=> phase == PH_HALT)
    else $error("error report did not halt the checker");

  a_header_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> {1'b0, byte_count} < HDR_BYTES)
    else $error("header byte count out of range");

endmodule
